[sv/bsb_pkg.sv]
// Shared types and constants for the bitsliced AES S-box pipeline.
// Depends on nothing; every other file refers to it by scoped names.
package bsb_pkg;

    // One lane word: bits 7:0 carry the even-byte slice and bits 15:8 the odd-byte slice.
    localparam int HALF_W = 8;
    localparam int LANE_W = 2 * HALF_W;
    localparam int NUM_SLICES = 8;
    localparam int HALF_DATA_W = HALF_W * NUM_SLICES;

    // Pipeline depth from input register to output register.
    localparam int PIPE_DEPTH = 5;

    typedef logic [LANE_W-1:0] lane_t;
    typedef lane_t [NUM_SLICES-1:0] slices_t;

    // The affine constant 0x63 flips output slices 1, 2, 6 and 7 in both halves.
    localparam lane_t AFFINE_MASK = lane_t'({2{8'hFF}});

    // Output of the top linear layer.
    typedef struct packed {
        lane_t [21:1] y;
        lane_t        u7;
    } top_lin_t;

    // The 18 products that feed the bottom linear layer.
    typedef lane_t [17:0] prod_t;

endpackage

[sv/bitsliced_aes_sbox_top.sv]
// Bitsliced AES SubBytes on a full 128-bit state, Boyar-Peralta gate circuit.
// An accepted item passes five stages, one register each, before its result is valid.
// Throughput: one item per cycle unless m_tready stalls; each stage holds one item.
// Ready is combinational; s_tready is low only with all stages full and m_tready low.
// Reset clears only the stage valid bits (asynchronous, active low); data is not reset.
// Depends on bsb_pkg, bsb_top_linear, bsb_nonlinear and bsb_bottom_linear.
module bitsliced_aes_sbox_top
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [63:0] even_half_slices, [127:64] odd_half_slices
    input  logic [127:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [63:0] even_half_substituted, [127:64] odd_half_substituted
    output logic [127:0] m_tdata
);

    localparam int HW = bsb_pkg::HALF_W;
    localparam int HD = bsb_pkg::HALF_DATA_W;

    // Both halves run through one circuit: each gate works on a 16-bit lane word whose
    // low byte is the even-half slice and whose high byte is the odd-half slice.
    bsb_pkg::slices_t  in_lanes;
    bsb_pkg::slices_t  out_lanes;
    bsb_pkg::top_lin_t lin_data;
    bsb_pkg::prod_t    prod_data;

    logic lin_valid;
    logic lin_ready;
    logic prod_valid;
    logic prod_ready;

    // Items in flight, for the checks below.
    logic [2:0] occ_reg;
    logic [2:0] occ_next;

    always_comb
    begin
        for (int k = 0; k < bsb_pkg::NUM_SLICES; k++)
        begin
            in_lanes[k] = {s_tdata[HD + HW*k +: HW], s_tdata[HW*k +: HW]};
            m_tdata[HW*k +: HW]      = out_lanes[k][HW-1:0];
            m_tdata[HD + HW*k +: HW] = out_lanes[k][2*HW-1:HW];
        end
    end

    // Stage 1: top linear layer.
    bsb_top_linear u_top_linear
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (in_lanes),
        .out_valid (lin_valid),
        .out_ready (lin_ready),
        .out_data  (lin_data)
    );

    // Stages 2 to 4: inversion core and output products.
    bsb_nonlinear u_nonlinear
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (lin_valid),
        .in_ready  (lin_ready),
        .in_data   (lin_data),
        .out_valid (prod_valid),
        .out_ready (prod_ready),
        .out_data  (prod_data)
    );

    // Stage 5: bottom linear layer with the affine constant, doubles as output register.
    bsb_bottom_linear u_bottom_linear
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prod_valid),
        .in_ready  (prod_ready),
        .in_data   (prod_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_lanes)
    );

    always_comb
    begin
        occ_next = occ_reg;
        if (s_tvalid && s_tready)
            occ_next = occ_next + 3'd1;
        if (m_tvalid && m_tready)
            occ_next = occ_next - 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            occ_reg <= '0;
        else
            occ_reg <= occ_next;
    end

    // Never more items in flight than pipeline stages.
    assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= 3'(bsb_pkg::PIPE_DEPTH))
    else $error("more items in flight than pipeline stages");

    // An empty output stage means the whole ready chain is open.
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
    else $error("input stalled while output stage is empty");

    // Input backpressure only when every stage holds an item.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> occ_reg == 3'(bsb_pkg::PIPE_DEPTH))
    else $error("input stalled with a stage empty");

    // A result is shown only when an item is in flight.
    assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg == 3'd0 |-> !m_tvalid)
    else $error("result shown with no item in flight");

endmodule

[sv/bsb_top_linear.sv]
// First pipeline stage: top linear layer of the S-box circuit.
// Depends on bsb_pkg for the lane and stage types.
module bsb_top_linear
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  bsb_pkg::slices_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output bsb_pkg::top_lin_t out_data
);

    bsb_pkg::lane_t    t0;
    bsb_pkg::lane_t    t1;
    bsb_pkg::top_lin_t lin_next;
    bsb_pkg::top_lin_t lin_reg;
    logic              valid_reg;

    always_comb
    begin
        lin_next       = '0;
        lin_next.u7    = in_data[7];
        lin_next.y[14] = in_data[3] ^ in_data[5];
        lin_next.y[13] = in_data[0] ^ in_data[6];
        lin_next.y[12] = lin_next.y[13] ^ lin_next.y[14];
        lin_next.y[9]  = in_data[0] ^ in_data[3];
        lin_next.y[8]  = in_data[0] ^ in_data[5];
        t0             = in_data[1] ^ in_data[2];
        lin_next.y[1]  = t0 ^ in_data[7];
        lin_next.y[4]  = lin_next.y[1] ^ in_data[3];
        lin_next.y[2]  = lin_next.y[1] ^ in_data[0];
        lin_next.y[5]  = lin_next.y[1] ^ in_data[6];
        t1             = in_data[4] ^ lin_next.y[12];
        lin_next.y[3]  = lin_next.y[5] ^ lin_next.y[8];
        lin_next.y[15] = t1 ^ in_data[5];
        lin_next.y[20] = t1 ^ in_data[1];
        lin_next.y[6]  = lin_next.y[15] ^ in_data[7];
        lin_next.y[10] = lin_next.y[15] ^ t0;
        lin_next.y[11] = lin_next.y[20] ^ lin_next.y[9];
        lin_next.y[7]  = in_data[7] ^ lin_next.y[11];
        lin_next.y[17] = lin_next.y[10] ^ lin_next.y[11];
        lin_next.y[19] = lin_next.y[10] ^ lin_next.y[8];
        lin_next.y[16] = t0 ^ lin_next.y[11];
        lin_next.y[21] = lin_next.y[13] ^ lin_next.y[16];
        lin_next.y[18] = in_data[0] ^ lin_next.y[16];
    end

    // Take a new item when empty or when the held one leaves this cycle.
    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            lin_reg <= lin_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = lin_reg;

endmodule

[sv/bsb_nonlinear.sv]
// Stages two to four: the GF(2^4)-based inversion core and the 18 output products.
// Depends on bsb_pkg for the lane and stage types.
module bsb_nonlinear
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  bsb_pkg::top_lin_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output bsb_pkg::prod_t    out_data
);

    typedef struct packed {
        bsb_pkg::lane_t [21:1] y;
        bsb_pkg::lane_t        u7;
        bsb_pkg::lane_t        t22;
        bsb_pkg::lane_t        t23;
        bsb_pkg::lane_t        t24;
        bsb_pkg::lane_t        t25;
        bsb_pkg::lane_t        t27;
        bsb_pkg::lane_t        t30;
        bsb_pkg::lane_t        t31;
    } mid_a_t;

    typedef struct packed {
        bsb_pkg::lane_t [21:1] y;
        bsb_pkg::lane_t        u7;
        bsb_pkg::lane_t        t25;
        bsb_pkg::lane_t        t29;
        bsb_pkg::lane_t        t33;
        bsb_pkg::lane_t        t37;
        bsb_pkg::lane_t        t38;
    } mid_b_t;

    // Stage A logic
    bsb_pkg::lane_t t2, t3, t4, t5, t6, t7, t8, t9, t10, t11, t12;
    bsb_pkg::lane_t t13, t14, t15, t16, t17, t18, t19, t20, t21, t26;
    // Stage B logic
    bsb_pkg::lane_t t28, t32, t34, t35, t36;
    // Stage C logic
    bsb_pkg::lane_t t39, t40, t41, t42, t43, t44, t45;

    mid_a_t         a_next;
    mid_a_t         a_reg;
    mid_b_t         b_next;
    mid_b_t         b_reg;
    bsb_pkg::prod_t z_next;
    bsb_pkg::prod_t z_reg;

    logic a_valid_reg;
    logic b_valid_reg;
    logic z_valid_reg;
    logic a_ready;
    logic b_ready;
    logic z_ready;

    always_comb
    begin
        t2  = in_data.y[12] & in_data.y[15];
        t3  = in_data.y[3] & in_data.y[6];
        t4  = t3 ^ t2;
        t5  = in_data.y[4] & in_data.u7;
        t6  = t5 ^ t2;
        t7  = in_data.y[13] & in_data.y[16];
        t8  = in_data.y[5] & in_data.y[1];
        t9  = t8 ^ t7;
        t10 = in_data.y[2] & in_data.y[7];
        t11 = t10 ^ t7;
        t12 = in_data.y[9] & in_data.y[11];
        t13 = in_data.y[14] & in_data.y[17];
        t14 = t13 ^ t12;
        t15 = in_data.y[8] & in_data.y[10];
        t16 = t15 ^ t12;
        t17 = t4 ^ t14;
        t18 = t6 ^ t16;
        t19 = t9 ^ t14;
        t20 = t11 ^ t16;
        t21 = t17 ^ in_data.y[20];

        a_next.y   = in_data.y;
        a_next.u7  = in_data.u7;
        a_next.t22 = t18 ^ in_data.y[19];
        a_next.t23 = t19 ^ in_data.y[21];
        a_next.t24 = t20 ^ in_data.y[18];
        a_next.t25 = t21 ^ a_next.t22;
        t26        = t21 & a_next.t23;
        a_next.t27 = a_next.t24 ^ t26;
        a_next.t30 = a_next.t23 ^ a_next.t24;
        a_next.t31 = a_next.t22 ^ t26;
    end

    always_comb
    begin
        t28        = a_reg.t25 & a_reg.t27;
        t32        = a_reg.t31 & a_reg.t30;
        b_next.y   = a_reg.y;
        b_next.u7  = a_reg.u7;
        b_next.t25 = a_reg.t25;
        b_next.t29 = t28 ^ a_reg.t22;
        b_next.t33 = t32 ^ a_reg.t24;
        t34        = a_reg.t23 ^ b_next.t33;
        t35        = a_reg.t27 ^ b_next.t33;
        t36        = a_reg.t24 & t35;
        b_next.t37 = t36 ^ t34;
        b_next.t38 = a_reg.t27 ^ t36;
    end

    always_comb
    begin
        t39 = b_reg.t29 & b_reg.t38;
        t40 = b_reg.t25 ^ t39;
        t41 = t40 ^ b_reg.t37;
        t42 = b_reg.t29 ^ b_reg.t33;
        t43 = b_reg.t29 ^ t40;
        t44 = b_reg.t33 ^ b_reg.t37;
        t45 = t42 ^ t41;

        z_next[0]  = t44 & b_reg.y[15];
        z_next[1]  = b_reg.t37 & b_reg.y[6];
        z_next[2]  = b_reg.t33 & b_reg.u7;
        z_next[3]  = t43 & b_reg.y[16];
        z_next[4]  = t40 & b_reg.y[1];
        z_next[5]  = b_reg.t29 & b_reg.y[7];
        z_next[6]  = t42 & b_reg.y[11];
        z_next[7]  = t45 & b_reg.y[17];
        z_next[8]  = t41 & b_reg.y[10];
        z_next[9]  = t44 & b_reg.y[12];
        z_next[10] = b_reg.t37 & b_reg.y[3];
        z_next[11] = b_reg.t33 & b_reg.y[4];
        z_next[12] = t43 & b_reg.y[13];
        z_next[13] = t40 & b_reg.y[5];
        z_next[14] = b_reg.t29 & b_reg.y[2];
        z_next[15] = t42 & b_reg.y[9];
        z_next[16] = t45 & b_reg.y[14];
        z_next[17] = t41 & b_reg.y[8];
    end

    // Each stage advances when empty or when the stage after it takes its item.
    assign z_ready  = !z_valid_reg || out_ready;
    assign b_ready  = !b_valid_reg || z_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            z_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
                a_valid_reg <= in_valid;
            if (b_ready)
                b_valid_reg <= a_valid_reg;
            if (z_ready)
                z_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
            a_reg <= a_next;
        if (b_ready && a_valid_reg)
            b_reg <= b_next;
        if (z_ready && b_valid_reg)
            z_reg <= z_next;
    end

    assign out_valid = z_valid_reg;
    assign out_data  = z_reg;

endmodule

[sv/bsb_bottom_linear.sv]
// Last pipeline stage: bottom linear layer, affine constant, output register.
// Depends on bsb_pkg for the lane types and the affine mask.
module bsb_bottom_linear
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  bsb_pkg::prod_t   in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output bsb_pkg::slices_t out_data
);

    bsb_pkg::lane_t t46, t47, t48, t49, t50, t51, t52, t53, t54, t55, t56;
    bsb_pkg::lane_t t57, t58, t59, t60, t61, t62, t63, t64, t65, t66, t67;

    bsb_pkg::slices_t s_next;
    bsb_pkg::slices_t s_reg;
    logic             valid_reg;

    always_comb
    begin
        t46 = in_data[15] ^ in_data[16];
        t47 = in_data[10] ^ in_data[11];
        t48 = in_data[5] ^ in_data[13];
        t49 = in_data[9] ^ in_data[10];
        t50 = in_data[2] ^ in_data[12];
        t51 = in_data[2] ^ in_data[5];
        t52 = in_data[7] ^ in_data[8];
        t53 = in_data[0] ^ in_data[3];
        t54 = in_data[6] ^ in_data[7];
        t55 = in_data[16] ^ in_data[17];
        t56 = in_data[12] ^ t48;
        t57 = t50 ^ t53;
        t58 = in_data[4] ^ t46;
        t59 = in_data[3] ^ t54;
        t60 = t46 ^ t57;
        t61 = in_data[14] ^ t57;
        t62 = t52 ^ t58;
        t63 = t49 ^ t58;
        t64 = in_data[4] ^ t59;
        t65 = t61 ^ t62;
        t66 = in_data[1] ^ t63;
        t67 = t64 ^ t65;

        s_next[0] = t59 ^ t63;
        s_next[3] = t53 ^ t66;
        s_next[1] = t64 ^ s_next[3] ^ bsb_pkg::AFFINE_MASK;
        s_next[2] = t55 ^ t67 ^ bsb_pkg::AFFINE_MASK;
        s_next[4] = t51 ^ t66;
        s_next[5] = t47 ^ t65;
        s_next[6] = t56 ^ t62 ^ bsb_pkg::AFFINE_MASK;
        s_next[7] = t48 ^ t60 ^ bsb_pkg::AFFINE_MASK;
    end

    // Hold the result until taken; accept the next item in the same cycle it leaves.
    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            s_reg <= s_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = s_reg;

endmodule

[tb/bitsliced_aes_sbox_top_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench for bitsliced_aes_sbox_top: stream driver, stream monitor and a
// byte-wise S-box predictor built from GF(2^8) inversion and the affine map.
// Depends on bsb_pkg and the bitsliced_aes_sbox_top RTL.
module bitsliced_aes_sbox_top_test;

    localparam int HALF_BITS = bsb_pkg::HALF_DATA_W;
    localparam logic [7:0] AES_AFFINE_C = 8'h63;
    localparam logic [7:0] AES_REDUCE = 8'h1B;
    localparam int NUM_RANDOM = 1900;
    localparam int MAX_WAIT = 8;
    localparam int MAX_REPORTS = 10;

    // One item waiting to go in, with its lead-in gap and an optional drain before it.
    typedef struct {
        logic [HALF_BITS-1:0] even_half;
        logic [HALF_BITS-1:0] odd_half;
        int                   gap;
        bit                   drain_first;
    } sbox_request_t;

    typedef struct {
        logic [HALF_BITS-1:0] even_half;
        logic [HALF_BITS-1:0] odd_half;
    } sbox_result_t;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    // [63:0] even_half_slices, [127:64] odd_half_slices
    logic [127:0]   s_tdata = '0;
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    // [63:0] even_half_substituted, [127:64] odd_half_substituted
    logic [127:0]   m_tdata;

    sbox_request_t  pending_requests[$];
    sbox_result_t   expected_sbox[$];
    int             n_sent = 0;
    int             n_checked = 0;
    int             mismatch_count = 0;
    int             tx_wait = 0;
    int             rx_wait = 0;

    bitsliced_aes_sbox_top u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
        logic [7:0] p;
        p = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                p ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? AES_REDUCE : 8'h00);
        end
        return p;
    endfunction

    // Forward S-box: inverse as a^254 (zero maps to zero), then the affine map.
    function automatic logic [7:0] sbox_byte(logic [7:0] a);
        logic [7:0] sq;
        logic [7:0] inv;
        logic [7:0] res;
        sq = a;
        inv = 8'h01;
        for (int i = 1; i < 8; i++)
        begin
            sq = gf_mul(sq, sq);
            inv = gf_mul(inv, sq);
        end
        res = inv ^ AES_AFFINE_C;
        for (int n = 1; n <= 4; n++)
            res ^= (inv << n) | (inv >> (8 - n));
        return res;
    endfunction

    // Swap between byte order (byte i in bits 8i+7:8i) and slice order
    // (bit 7-k of byte i at bit 8k+7-i). The map is its own inverse.
    function automatic logic [HALF_BITS-1:0] transpose_slices(logic [HALF_BITS-1:0] w);
        logic [HALF_BITS-1:0] t;
        for (int k = 0; k < 8; k++)
            for (int i = 0; i < 8; i++)
                t[8*k + 7 - i] = w[8*i + 7 - k];
        return t;
    endfunction

    function automatic logic [HALF_BITS-1:0] substitute_half(logic [HALF_BITS-1:0] slices);
        logic [HALF_BITS-1:0] bytes;
        bytes = transpose_slices(slices);
        for (int i = 0; i < 8; i++)
            bytes[8*i +: 8] = sbox_byte(bytes[8*i +: 8]);
        return transpose_slices(bytes);
    endfunction

    function automatic int rx_stall_draw(int count);
        // leave a stretch of every 256 results with the sink always ready
        return (count % 256 < 48) ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    task automatic note_mismatch(string what, logic [HALF_BITS-1:0] want,
                                 logic [HALF_BITS-1:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch on result %0d, %s: expected %h, got %h",
                     n_checked, what, want, got);
    endtask

    task automatic queue_request(logic [HALF_BITS-1:0] even_half,
                                 logic [HALF_BITS-1:0] odd_half, int gap, bit drain_first);
        sbox_request_t req;
        req.even_half = even_half;
        req.odd_half = odd_half;
        req.gap = gap;
        req.drain_first = drain_first;
        pending_requests.push_back(req);
    endtask

    // ------------------------------------------------------------------
    // Driver: present queued items, predict each one as it is accepted
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        sbox_result_t want;
        logic         nxt_valid;
        int           sent_now;
        if (rst_n)
        begin
            nxt_valid = s_tvalid;
            sent_now = n_sent;
            if (s_tvalid && s_tready)
            begin
                want.even_half = substitute_half(s_tdata[63:0]);
                want.odd_half = substitute_half(s_tdata[127:64]);
                expected_sbox.push_back(want);
                sent_now = n_sent + 1;
                n_sent <= sent_now;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid && pending_requests.size() != 0)
            begin
                if (tx_wait < pending_requests[0].gap)
                    tx_wait++;
                // hold until every outstanding result is back
                else if (!(pending_requests[0].drain_first && sent_now != n_checked))
                begin
                    s_tdata <= {pending_requests[0].odd_half, pending_requests[0].even_half};
                    void'(pending_requests.pop_front());
                    tx_wait = 0;
                    nxt_valid = 1'b1;
                end
            end
            s_tvalid <= nxt_valid;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare every accepted result with the oldest prediction
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        sbox_result_t want;
        logic         nxt_ready;
        if (rst_n)
        begin
            nxt_ready = m_tready;
            if (m_tvalid && m_tready)
            begin
                if (expected_sbox.size() == 0)
                    note_mismatch("unexpected result", '0, m_tdata[63:0]);
                else
                begin
                    want = expected_sbox.pop_front();
                    if (m_tdata[63:0] !== want.even_half)
                        note_mismatch("even_half_substituted", want.even_half, m_tdata[63:0]);
                    if (m_tdata[127:64] !== want.odd_half)
                        note_mismatch("odd_half_substituted", want.odd_half, m_tdata[127:64]);
                end
                n_checked <= n_checked + 1;
                rx_wait = rx_stall_draw(n_checked);
                nxt_ready = (rx_wait == 0);
            end
            else if (!m_tready)
            begin
                if (rx_wait > 0)
                    rx_wait--;
                nxt_ready = (rx_wait == 0);
            end
            m_tready <= nxt_ready;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------

    initial
    begin
        logic [HALF_BITS-1:0] even_bytes;
        logic [HALF_BITS-1:0] odd_bytes;
        int                   gap;

        // extremes: all zero, all one, alternating patterns both ways
        queue_request('0, '0, 0, 1'b0);
        queue_request('1, '1, 0, 1'b0);
        queue_request({8{8'h55}}, {8{8'hAA}}, 1, 1'b0);
        queue_request({8{8'hAA}}, {8{8'h55}}, 0, 1'b0);
        // every byte value once across sixteen items, each half in slice form
        for (int j = 0; j < 16; j++)
        begin
            for (int i = 0; i < 8; i++)
            begin
                even_bytes[8*i +: 8] = 8'(16 * j + i);
                odd_bytes[8*i +: 8] = 8'(16 * j + 8 + i);
            end
            queue_request(transpose_slices(even_bytes), transpose_slices(odd_bytes),
                          $urandom_range(0, 2), j == 8);
        end

        // random slices; stretches of back-to-back items between idle ones
        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            gap = (n % 256 < 64) ? 0 : $urandom_range(0, MAX_WAIT);
            queue_request({$urandom, $urandom}, {$urandom, $urandom}, gap, n % 400 == 200);
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_requests.size() != 0 || s_tvalid)
            @(posedge clk);
        while (n_sent != n_checked)
            @(posedge clk);
        // give a stray extra result time to show up
        repeat (4 * bsb_pkg::PIPE_DEPTH + MAX_WAIT) @(posedge clk);

        if (mismatch_count == 0 && expected_sbox.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Generous bound on the slowest legal run.
    initial
    begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
